[rtl/core/dmrl_pkg.sv]
// Shared types, register indexes and reset constants for the dual motor ramp limiter.
// Used by dmrl_ramp and dual_motor_ramp_limiter; depends on nothing else.
package dmrl_pkg;

  localparam int unsigned SPD_W    = 9;
  localparam int unsigned CMD_W    = 16;
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned AGE_W    = 16;
  localparam int unsigned RAMP_W   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DUTY_BITS_DEF = 8;

  localparam logic [RAMP_W-1:0] RAMP_PERIOD_RST = 8'd10;
  localparam logic [AGE_W-1:0]  TIMEOUT_RST     = 16'd1000;
  localparam logic [7:0]        LIMIT_RST       = 8'd250;
  localparam logic [7:0]        STEP_RST        = 8'd5;
  localparam logic [7:0]        KICK_RST        = 8'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_PERIOD = 3'd0,
    REG_TIMEOUT     = 3'd1,
    REG_THR_LIMIT   = 3'd2,
    REG_STR_LIMIT   = 3'd3,
    REG_THR_STEP    = 3'd4,
    REG_STR_STEP    = 3'd5,
    REG_THR_KICK    = 3'd6,
    REG_STR_KICK    = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_CMD  = 1'b1
  } func_e;

  // Per-motor ramp settings handed to a ramp unit
  typedef struct packed {
    logic [7:0] step;
    logic [7:0] kick;
  } ramp_cfg_t;

  // One result transaction, lowest field last
  typedef struct packed {
    logic                    fired;
    logic signed [SPD_W-1:0] spd_str;
    logic signed [SPD_W-1:0] spd_thr;
    logic [DUTY_W-1:0]       b2;
    logic [DUTY_W-1:0]       b1;
    logic [DUTY_W-1:0]       a2;
    logic [DUTY_W-1:0]       a1;
  } result_t;

  // Clamp a signed command to +-lim
  function automatic logic signed [SPD_W-1:0] clamp_mag(logic signed [CMD_W-1:0] v,
                                                        logic [7:0] lim);
    logic signed [CMD_W:0] v_x;
    logic signed [CMD_W:0] l_x;
    logic signed [SPD_W-1:0] res;
    v_x = {v[CMD_W-1], v};
    l_x = signed'({9'b0, lim});
    if (v_x > l_x) begin
      res = signed'({1'b0, lim});
    end else if (v_x < -l_x) begin
      res = -signed'({1'b0, lim});
    end else begin
      res = v[SPD_W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [10:0] abs11(logic signed [10:0] v);
    return v[10] ? -v : v;
  endfunction

endpackage

[rtl/core/dmrl_ramp.sv]
// Slew-rate step with kick start for one motor: zero target stops, standstill kicks,
// otherwise step toward target. Depends on dmrl_pkg.
module dmrl_ramp
  import dmrl_pkg::*;
(
  input  logic signed [SPD_W-1:0] cur_i,
  input  logic signed [SPD_W-1:0] tgt_i,
  input  ramp_cfg_t               cfg_i,
  output logic signed [SPD_W-1:0] spd_o
);

  logic signed [10:0] cur_x, tgt_x, kick_x, step_x;
  logic signed [10:0] start, clip, diff, moved;

  always_comb begin
    cur_x  = {{2{cur_i[SPD_W-1]}}, cur_i};
    tgt_x  = {{2{tgt_i[SPD_W-1]}}, tgt_i};
    kick_x = signed'({3'b0, cfg_i.kick});
    step_x = signed'({3'b0, cfg_i.step});

    // leave standstill with a kick in the target's direction
    if (cur_x == 11'sd0) begin
      start = (tgt_x > 11'sd0) ? kick_x : -kick_x;
    end else begin
      start = cur_x;
    end

    // never overshoot the target magnitude
    clip = (abs11(start) > abs11(tgt_x)) ? tgt_x : start;
    diff = tgt_x - clip;

    if (abs11(diff) > step_x) begin
      moved = (tgt_x > clip) ? clip + step_x : clip - step_x;
    end else begin
      moved = tgt_x;
    end

    spd_o = (tgt_x == 11'sd0) ? '0 : moved[SPD_W-1:0];
  end

endmodule

[rtl/core/dual_motor_ramp_limiter.sv]
// Dual motor ramp limiter: throttle and steering slew-rate limiters with kick start,
// command watchdog and H-bridge duty mapping. Depends on dmrl_pkg and dmrl_ramp.
//
// Each input transaction is either a one-millisecond tick (tuser = 0) or a new target
// command (tuser = 1) and yields exactly one result transaction. The block accepts one
// transaction per clock unless the result side stalls; the input register holds the
// transaction, the state update runs between the input register and the result register,
// and the result register loads when it is free.
// While a finished result waits, the input register still takes one more transaction.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them
// only while the block is idle, which the block itself leaves unenforced; there is no read-back.
module dual_motor_ramp_limiter
  import dmrl_pkg::*;
#(
  parameter int unsigned DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] cmd_throttle, [31:16] cmd_steer
  input  logic [31:0]           s_axis_tdata,
  // [0] func
  input  logic                  s_axis_tuser,

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] drive_a1, [15:8] drive_a2, [23:16] drive_b1, [31:24] drive_b2,
  // [40:32] speed_throttle, [49:41] speed_steer, [50] timeout_fired, [55:51] zero
  output logic [55:0]           m_axis_tdata
);

  localparam logic [16:0] DutyMax = 17'((1 << DUTY_BITS) - 1);

  // configuration
  logic [RAMP_W-1:0] ramp_period_q;
  logic [AGE_W-1:0]  timeout_q;
  logic [7:0]        thr_limit_q, str_limit_q;
  ramp_cfg_t         thr_cfg_q, str_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_period_q  <= RAMP_PERIOD_RST;
      timeout_q      <= TIMEOUT_RST;
      thr_limit_q    <= LIMIT_RST;
      str_limit_q    <= LIMIT_RST;
      thr_cfg_q.step <= STEP_RST;
      str_cfg_q.step <= STEP_RST;
      thr_cfg_q.kick <= KICK_RST;
      str_cfg_q.kick <= KICK_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_RAMP_PERIOD: ramp_period_q  <= cfg_data_i[7:0];
        REG_TIMEOUT:     timeout_q      <= cfg_data_i;
        REG_THR_LIMIT:   thr_limit_q    <= cfg_data_i[7:0];
        REG_STR_LIMIT:   str_limit_q    <= cfg_data_i[7:0];
        REG_THR_STEP:    thr_cfg_q.step <= cfg_data_i[7:0];
        REG_STR_STEP:    str_cfg_q.step <= cfg_data_i[7:0];
        REG_THR_KICK:    thr_cfg_q.kick <= cfg_data_i[7:0];
        REG_STR_KICK:    str_cfg_q.kick <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                    in_valid_q;
  func_e                   in_func_q;
  logic signed [CMD_W-1:0] in_thr_q, in_str_q;
  logic                    out_valid_q;
  result_t                 out_q;
  logic                    out_free, adv;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q <= func_e'(s_axis_tuser);
      in_thr_q  <= s_axis_tdata[15:0];
      in_str_q  <= s_axis_tdata[31:16];
    end
  end

  // motor state
  logic signed [SPD_W-1:0] tgt_thr_q, tgt_str_q, spd_thr_q, spd_str_q;
  logic signed [SPD_W-1:0] tgt_thr_d, tgt_str_d, spd_thr_d, spd_str_d;
  logic signed [SPD_W-1:0] ramp_thr, ramp_str;
  logic [AGE_W-1:0]        cmd_age_q, cmd_age_d, age_inc;
  logic [RAMP_W-1:0]       ramp_age_q, ramp_age_d, ramp_inc;
  logic                    fire, upd;

  dmrl_ramp u_ramp_thr (
    .cur_i (spd_thr_q),
    .tgt_i (tgt_thr_d),
    .cfg_i (thr_cfg_q),
    .spd_o (ramp_thr)
  );

  dmrl_ramp u_ramp_str (
    .cur_i (spd_str_q),
    .tgt_i (tgt_str_d),
    .cfg_i (str_cfg_q),
    .spd_o (ramp_str)
  );

  always_comb begin
    age_inc  = (cmd_age_q == '1) ? cmd_age_q : cmd_age_q + AGE_W'(1);
    ramp_inc = (ramp_age_q == '1) ? ramp_age_q : ramp_age_q + RAMP_W'(1);
    fire     = 1'b0;
    upd      = 1'b0;

    tgt_thr_d  = tgt_thr_q;
    tgt_str_d  = tgt_str_q;
    cmd_age_d  = cmd_age_q;
    ramp_age_d = ramp_age_q;

    if (in_func_q == FUNC_CMD) begin
      tgt_thr_d = clamp_mag(in_thr_q, thr_limit_q);
      tgt_str_d = clamp_mag(in_str_q, str_limit_q);
      cmd_age_d = '0;
    end else begin
      cmd_age_d = age_inc;
      // watchdog first, so the ramp sees the zeroed targets
      fire = ((tgt_thr_q != '0) || (tgt_str_q != '0)) && (age_inc > timeout_q);
      if (fire) begin
        tgt_thr_d = '0;
        tgt_str_d = '0;
      end
      upd        = (ramp_inc >= ramp_period_q);
      ramp_age_d = upd ? '0 : ramp_inc;
    end

    spd_thr_d = upd ? ramp_thr : spd_thr_q;
    spd_str_d = upd ? ramp_str : spd_str_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_thr_q  <= '0;
      tgt_str_q  <= '0;
      spd_thr_q  <= '0;
      spd_str_q  <= '0;
      cmd_age_q  <= '0;
      ramp_age_q <= '0;
    end else if (adv) begin
      tgt_thr_q  <= tgt_thr_d;
      tgt_str_q  <= tgt_str_d;
      spd_thr_q  <= spd_thr_d;
      spd_str_q  <= spd_str_d;
      cmd_age_q  <= cmd_age_d;
      ramp_age_q <= ramp_age_d;
    end
  end

  // duty mapping
  logic [SPD_W-1:0]  mag_thr, mag_str;
  logic [DUTY_W-1:0] duty_thr, duty_str;
  result_t           res_d;

  always_comb begin
    mag_thr  = spd_thr_d[SPD_W-1] ? SPD_W'(-spd_thr_d) : SPD_W'(spd_thr_d);
    mag_str  = spd_str_d[SPD_W-1] ? SPD_W'(-spd_str_d) : SPD_W'(spd_str_d);
    duty_thr = ({8'b0, mag_thr} > DutyMax) ? DutyMax[DUTY_W-1:0] : mag_thr[DUTY_W-1:0];
    duty_str = ({8'b0, mag_str} > DutyMax) ? DutyMax[DUTY_W-1:0] : mag_str[DUTY_W-1:0];

    res_d.a1      = (spd_thr_d > 9'sd0) ? duty_thr : '0;
    res_d.a2      = (spd_thr_d < 9'sd0) ? duty_thr : '0;
    // steering bridge is wired mirrored
    res_d.b1      = (spd_str_d < 9'sd0) ? duty_str : '0;
    res_d.b2      = (spd_str_d > 9'sd0) ? duty_str : '0;
    res_d.spd_thr = spd_thr_d;
    res_d.spd_str = spd_str_d;
    res_d.fired   = fire;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q};

  // checks
  a_fire_zeroes_targets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && fire) |=> (tgt_thr_q == '0 && tgt_str_q == '0))
    else $error("watchdog fired but targets not cleared");

  a_cmd_keeps_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_func_q == FUNC_CMD) |=> ($stable(spd_thr_q) && $stable(spd_str_q)))
    else $error("speed changed on a command transaction");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (spd_thr_q != 9'h100) && (spd_str_q != 9'h100))
    else $error("speed left the +-255 range");

  a_one_side_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!((out_q.a1 != '0) && (out_q.a2 != '0)) &&
                     !((out_q.b1 != '0) && (out_q.b2 != '0))))
    else $error("both halves of a bridge driven");

endmodule

[bench/dmrl_checker.sv]
`timescale 1ns / 100ps
// Checker for the dual motor ramp limiter: watches the register port and both streams,
// predicts each result transaction and compares it field by field. Depends on dmrl_pkg.
module dmrl_checker
  import dmrl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [31:0]           in_data_i,
  input  logic                  in_func_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [55:0]           out_data_i,
  output int unsigned           mismatches_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o,
  output int unsigned           trips_o
);

  localparam int DUTY_MAX = (1 << DUTY_BITS_DEF) - 1;

  logic [7:0]              ramp_period;
  logic [15:0]             cmd_timeout;
  logic [7:0]              thr_limit, str_limit, thr_step, str_step, thr_kick, str_kick;
  logic signed [SPD_W-1:0] tgt_thr, tgt_str, spd_thr, spd_str;
  logic [7:0]              ramp_age;
  logic [15:0]             cmd_age;
  result_t                 drive_q[$];

  function automatic int mag_of(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [SPD_W-1:0] clamp_cmd(logic [15:0] raw, logic [7:0] lim);
    int v;
    int l;
    v = int'(signed'(raw));
    l = int'(lim);
    if (v > l) v = l;
    else if (v < -l) v = -l;
    return v[SPD_W-1:0];
  endfunction

  // Move one speed toward its target: stop on zero, kick from standstill, then step
  function automatic logic signed [SPD_W-1:0] slew(logic signed [SPD_W-1:0] cur,
                                                  logic signed [SPD_W-1:0] tgt,
                                                  logic [7:0] step, logic [7:0] kick);
    int c;
    int t;
    int d;
    c = int'(cur);
    t = int'(tgt);
    if (t == 0) return '0;
    if (c == 0) c = (t > 0) ? int'(kick) : -int'(kick);
    if (mag_of(c) > mag_of(t)) c = t;
    d = t - c;
    if (mag_of(d) > int'(step)) c = (t > c) ? c + int'(step) : c - int'(step);
    else c = t;
    return c[SPD_W-1:0];
  endfunction

  function automatic logic [DUTY_W-1:0] duty_of(logic signed [SPD_W-1:0] s);
    int m;
    m = mag_of(int'(s));
    return (m > DUTY_MAX) ? DUTY_W'(DUTY_MAX) : m[DUTY_W-1:0];
  endfunction

  function automatic result_t advance(logic func, logic [31:0] data);
    result_t r;
    r = '0;
    if (func_e'(func) == FUNC_CMD) begin
      tgt_thr = clamp_cmd(data[15:0], thr_limit);
      tgt_str = clamp_cmd(data[31:16], str_limit);
      cmd_age = '0;
    end else begin
      if (cmd_age != 16'hFFFF) cmd_age++;
      if ((tgt_thr != 0 || tgt_str != 0) && cmd_age > cmd_timeout) begin
        tgt_thr = '0;
        tgt_str = '0;
        r.fired = 1'b1;
        trips_o++;
      end
      if (ramp_age != 8'hFF) ramp_age++;
      if (ramp_age >= ramp_period) begin
        ramp_age = '0;
        spd_thr = slew(spd_thr, tgt_thr, thr_step, thr_kick);
        spd_str = slew(spd_str, tgt_str, str_step, str_kick);
      end
    end
    r.a1 = (spd_thr > 0) ? duty_of(spd_thr) : '0;
    r.a2 = (spd_thr < 0) ? duty_of(spd_thr) : '0;
    // steering bridge is wired mirrored
    r.b1 = (spd_str < 0) ? duty_of(spd_str) : '0;
    r.b2 = (spd_str > 0) ? duty_of(spd_str) : '0;
    r.spd_thr = spd_thr;
    r.spd_str = spd_str;
    return r;
  endfunction

  function automatic void compare_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches_o++;
    end
  endfunction

  function automatic void check_result(logic [55:0] raw);
    result_t want;
    result_t seen;
    if (drive_q.size() == 0) begin
      $error("result transaction with nothing outstanding: tdata %h", raw);
      mismatches_o++;
      return;
    end
    want = drive_q.pop_front();
    seen = raw[50:0];
    checked_o++;
    compare_field("drive_a1", 32'(want.a1), 32'(seen.a1));
    compare_field("drive_a2", 32'(want.a2), 32'(seen.a2));
    compare_field("drive_b1", 32'(want.b1), 32'(seen.b1));
    compare_field("drive_b2", 32'(want.b2), 32'(seen.b2));
    compare_field("speed_throttle", 32'(want.spd_thr), 32'(seen.spd_thr));
    compare_field("speed_steer", 32'(want.spd_str), 32'(seen.spd_str));
    compare_field("timeout_fired", 32'(want.fired), 32'(seen.fired));
    compare_field("tdata padding", 0, 32'(raw[55:51]));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_period  = RAMP_PERIOD_RST;
      cmd_timeout  = TIMEOUT_RST;
      thr_limit    = LIMIT_RST;
      str_limit    = LIMIT_RST;
      thr_step     = STEP_RST;
      str_step     = STEP_RST;
      thr_kick     = KICK_RST;
      str_kick     = KICK_RST;
      tgt_thr      = '0;
      tgt_str      = '0;
      spd_thr      = '0;
      spd_str      = '0;
      ramp_age     = '0;
      cmd_age      = '0;
      drive_q.delete();
      mismatches_o = 0;
      checked_o    = 0;
      trips_o      = 0;
    end else begin
      // a result can never belong to a transaction taken at the same edge
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_RAMP_PERIOD: ramp_period = cfg_data_i[7:0];
          REG_TIMEOUT:     cmd_timeout = cfg_data_i;
          REG_THR_LIMIT:   thr_limit   = cfg_data_i[7:0];
          REG_STR_LIMIT:   str_limit   = cfg_data_i[7:0];
          REG_THR_STEP:    thr_step    = cfg_data_i[7:0];
          REG_STR_STEP:    str_step    = cfg_data_i[7:0];
          REG_THR_KICK:    thr_kick    = cfg_data_i[7:0];
          REG_STR_KICK:    str_kick    = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) drive_q.push_back(advance(in_func_i, in_data_i));
    end
    pending_o = drive_q.size();
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Top of the ramp limiter bench: clock, reset, register phases and stream stimulus.
// Depends on dmrl_pkg, dual_motor_ramp_limiter and dmrl_checker.
module tb;
  import dmrl_pkg::*;

  localparam int unsigned N_PHASES     = 14;
  localparam int unsigned RUN_LIMIT_NS = 3_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [55:0]           m_axis_tdata;

  int unsigned mismatches, pending, checked, trips;
  int unsigned sent;
  int unsigned gap_odds, stall_odds;
  logic [15:0] setting [8];
  logic [15:0] last_thr, last_str;

  dual_motor_ramp_limiter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  dmrl_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_func_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .trips_o      (trips)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: stall in random bursts, never while stall_odds is zero
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_item(input func_e f, input logic [15:0] thr, input logic [15:0] str);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {str, thr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  // Hold off until every result is back, then load all registers
  task automatic load_settings();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_idx_i  <= cfg_reg_e'(i);
      cfg_data_i <= setting[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_cmd(input logic [7:0] lim, input logic [15:0] prev);
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = 16'($urandom);
      2: v = '0;
      3: v = -prev;
      4: v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      5: v = {8'h00, lim} + 16'($urandom_range(0, 1));
      default: v = 16'($urandom_range(0, 300));
    endcase
    if (v != 16'h8000 && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic run_phase(input int unsigned n_items, input int unsigned cmd_odds);
    logic [15:0] thr;
    logic [15:0] str;
    for (int unsigned i = 0; i < n_items; i++) begin
      if ($urandom_range(1, cmd_odds) == 1) begin
        thr = pick_cmd(setting[REG_THR_LIMIT][7:0], last_thr);
        str = pick_cmd(setting[REG_STR_LIMIT][7:0], last_str);
        last_thr = thr;
        last_str = str;
        send_item(FUNC_CMD, thr, str);
      end else begin
        // tick payload is ignored by the block
        send_item(FUNC_TICK, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 2;
      2: return 6;
      default: return 15;
    endcase
  endfunction

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_TICK;
    sent          = 0;
    gap_odds      = 0;
    stall_odds    = 0;
    last_thr      = '0;
    last_str      = '0;
    setting[REG_RAMP_PERIOD] = 16'(RAMP_PERIOD_RST);
    setting[REG_TIMEOUT]     = TIMEOUT_RST;
    setting[REG_THR_LIMIT]   = 16'(LIMIT_RST);
    setting[REG_STR_LIMIT]   = 16'(LIMIT_RST);
    setting[REG_THR_STEP]    = 16'(STEP_RST);
    setting[REG_STR_STEP]    = 16'(STEP_RST);
    setting[REG_THR_KICK]    = 16'(KICK_RST);
    setting[REG_STR_KICK]    = 16'(KICK_RST);
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: full-scale commands both ways, kick, then reversed and then zero targets
    send_item(FUNC_CMD, 16'h7FFF, 16'h8000);
    repeat (10) send_item(FUNC_TICK, 16'hFFFF, 16'hFFFF);
    send_item(FUNC_CMD, 16'h8000, 16'h7FFF);
    repeat (10) send_item(FUNC_TICK, 16'h0000, 16'h0000);
    send_item(FUNC_CMD, 16'h0000, 16'h0000);
    send_item(FUNC_TICK, 16'h0000, 16'h0000);

    for (int unsigned phase = 1; phase < N_PHASES; phase++) begin
      case (phase)
        1: begin
          // every tick ramps, watchdog fires on the first tick, no kick
          setting[REG_RAMP_PERIOD] = 16'd0;
          setting[REG_TIMEOUT]     = 16'd0;
          setting[REG_THR_LIMIT]   = 16'd255;
          setting[REG_STR_LIMIT]   = 16'd255;
          setting[REG_THR_STEP]    = 16'd255;
          setting[REG_STR_STEP]    = 16'd255;
          setting[REG_THR_KICK]    = 16'd0;
          setting[REG_STR_KICK]    = 16'd0;
        end
        2: begin
          // no step: speed changes only by the kick and by clipping to the target; watchdog disabled
          setting[REG_RAMP_PERIOD] = 16'd1;
          setting[REG_TIMEOUT]     = 16'hFFFF;
          setting[REG_THR_STEP]    = 16'd0;
          setting[REG_STR_STEP]    = 16'd0;
          setting[REG_THR_KICK]    = 16'd255;
          setting[REG_STR_KICK]    = 16'd255;
        end
        3: begin
          // zero limits force every target to zero
          setting[REG_RAMP_PERIOD] = 16'd2;
          setting[REG_TIMEOUT]     = 16'd30;
          setting[REG_THR_LIMIT]   = 16'd0;
          setting[REG_STR_LIMIT]   = 16'd0;
          setting[REG_THR_STEP]    = 16'd1;
          setting[REG_STR_STEP]    = 16'd1;
        end
        4: begin
          setting[REG_RAMP_PERIOD] = 16'd255;
          setting[REG_TIMEOUT]     = 16'd65534;
          setting[REG_THR_LIMIT]   = 16'd255;
          setting[REG_STR_LIMIT]   = 16'd1;
          setting[REG_THR_STEP]    = 16'd1;
          setting[REG_STR_STEP]    = 16'd255;
          setting[REG_THR_KICK]    = 16'd0;
          setting[REG_STR_KICK]    = 16'd1;
        end
        default: begin
          setting[REG_RAMP_PERIOD] = {8'($urandom), 8'($urandom_range(0, 6))};
          setting[REG_TIMEOUT]     = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                : 16'($urandom_range(0, 80));
          setting[REG_THR_LIMIT]   = 16'($urandom);
          setting[REG_STR_LIMIT]   = 16'($urandom);
          setting[REG_THR_STEP]    = {8'($urandom), 8'($urandom_range(0, 40))};
          setting[REG_STR_STEP]    = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                : 16'($urandom_range(0, 40));
          setting[REG_THR_KICK]    = 16'($urandom);
          setting[REG_STR_KICK]    = 16'($urandom);
        end
      endcase
      load_settings();
      if (phase == N_PHASES - 1) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = pick_odds();
        stall_odds = pick_odds();
      end
      case (phase)
        1: run_phase(100, 4);
        2: run_phase(100, 10);
        3: run_phase(100, 5);
        4: run_phase(400, 150);
        default: run_phase(115, $urandom_range(2, 40));
      endcase
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    $display("covered %0d transactions over %0d register settings, %0d results checked",
             sent, N_PHASES, checked);
    $display("watchdog tripped %0d times", trips);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/dmrl_pkg.sv
rtl/core/dmrl_ramp.sv
rtl/core/dual_motor_ramp_limiter.sv
bench/dmrl_checker.sv
bench/tb.sv
